// ----- src/multicast_receive_window_defines.svh -----
// Assertion macros shared by the receive window RTL.
`ifndef MULTICAST_RECEIVE_WINDOW_DEFINES_SVH
`define MULTICAST_RECEIVE_WINDOW_DEFINES_SVH

`ifndef ASSERT_OFF

// Immediate implication, checked at every rising edge outside reset.
`define MRW_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// The consequent is checked in the cycle after the antecedent holds.
`define MRW_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define MRW_ASSERT(name, clk, rst_n, prop, msg)
`define MRW_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)

`endif

`endif

// ----- src/mrw_pkg.sv -----
package mrw_pkg;

  // Operation codes on the input word.
  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_GAP     = 2'd2;

  // Result kinds on the output word.
  localparam logic [1:0] KIND_CLOSE   = 2'd0;
  localparam logic [1:0] KIND_ENTRY   = 2'd1;
  localparam logic [1:0] KIND_MISSING = 2'd2;

  // Work the back end has to do for one queued word.
  typedef enum logic [1:0] {
    JOB_DATA    = 2'd0,
    JOB_RELEASE = 2'd1,
    JOB_GAP     = 2'd2,
    JOB_CLOSE   = 2'd3
  } job_e;

  // Classified word handed from the front end to the back end.
  typedef struct packed {
    job_e        job;
    logic [30:0] seq;
    logic [7:0]  sender;
    logic [30:0] value;
  } item_t;

  // One stored window entry.
  typedef struct packed {
    logic [30:0] seq;
    logic [7:0]  sender;
    logic [30:0] value;
  } entry_t;

endpackage

// ----- src/mrw_if.sv -----
// Input channel: one request word per handshake.
interface mrw_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] sequence_req;
  logic [7:0]         sender;
  logic [30:0]        value;

  modport source (output valid, operation, sequence_req, sender, value, input ready);
  modport sink   (input valid, operation, sequence_req, sender, value, output ready);
endinterface

// Output channel: one result word per handshake.
interface mrw_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [30:0]        out_sequence;
  logic [7:0]         out_sender;
  logic [30:0]        out_value;
  logic signed [31:0] all_received_mark;
  logic               last;

  modport source (output valid, kind, out_sequence, out_sender, out_value,
                  all_received_mark, last, input ready);
  modport sink   (input valid, kind, out_sequence, out_sender, out_value,
                  all_received_mark, last, output ready);
endinterface

// ----- src/mrw_ram.sv -----
module mrw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port; the read data holds when not enabled.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/mrw_front.sv -----
module mrw_front import mrw_pkg::*; #(
  parameter int unsigned WINDOW_SLOTS = 32,
  localparam int unsigned SLOT_W = $clog2(WINDOW_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mrw_in_if.sink            in_i,
  output logic              push_o,
  output item_t             item_o,
  output logic [SLOT_W-1:0] slot_o,
  input  logic              full_i
);

  localparam logic [SLOT_W+7:0] WIN_EXT = (SLOT_W+8)'(WINDOW_SLOTS);

  typedef enum logic [2:0] {
    FR_IDLE = 3'b001,
    FR_MOD  = 3'b010,
    FR_PUSH = 3'b100
  } fr_state_e;

  fr_state_e         state_q, state_d;
  item_t             item_q, item_d;
  logic [SLOT_W-1:0] rem_q, rem_d;
  logic [1:0]        byte_q, byte_d;
  logic [31:0]       seq_word;
  job_e              job_in;

  // Folds one byte into the running remainder modulo the window size.
  function automatic logic [SLOT_W-1:0] mod_step(logic [SLOT_W-1:0] r, logic [7:0] b);
    logic [SLOT_W+7:0] t;
    t = {r, b};
    for (int k = 7; k >= 0; k--) begin
      if (t >= (WIN_EXT << k)) begin
        t = t - (WIN_EXT << k);
      end
    end
    return t[SLOT_W-1:0];
  endfunction

  // Classify the incoming word; a negative sequence or an unknown code only closes.
  always_comb begin
    unique case (in_i.operation)
      OP_DATA:    job_in = JOB_DATA;
      OP_RELEASE: job_in = JOB_RELEASE;
      OP_GAP:     job_in = JOB_GAP;
      default:    job_in = JOB_CLOSE;
    endcase
    if (in_i.sequence_req[31]) begin
      job_in = JOB_CLOSE;
    end
  end

  assign seq_word = {1'b0, item_q.seq};

  // Accept, reduce a data or release sequence to a slot one byte per cycle, then queue.
  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    rem_d   = rem_q;
    byte_d  = byte_q;
    unique case (state_q)
      FR_IDLE: begin
        if (in_i.valid) begin
          item_d.job    = job_in;
          item_d.seq    = in_i.sequence_req[30:0];
          item_d.sender = in_i.sender;
          item_d.value  = in_i.value;
          rem_d         = '0;
          byte_d        = 2'd3;
          if (job_in == JOB_DATA || job_in == JOB_RELEASE) begin
            state_d = FR_MOD;
          end else begin
            state_d = FR_PUSH;
          end
        end
      end
      FR_MOD: begin
        rem_d  = mod_step(rem_q, seq_word[{byte_q, 3'b000} +: 8]);
        byte_d = byte_q - 2'd1;
        if (byte_q == 2'd0) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!full_i) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      byte_q  <= '0;
    end else begin
      state_q <= state_d;
      byte_q  <= byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rem_q  <= rem_d;
  end

  assign in_i.ready = (state_q == FR_IDLE);
  assign push_o     = (state_q == FR_PUSH) && !full_i;
  assign item_o     = item_q;
  assign slot_o     = rem_q;

endmodule

// ----- src/mrw_queue.sv -----
`include "multicast_receive_window_defines.svh"

module mrw_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  // Two-entry ring between the front and back ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_q];

  // The back end only retires a word that is there, and the front end never overfills.
  `MRW_ASSERT(a_pop_not_empty, clk_i, rst_ni, pop_i |-> cnt_q != 2'd0, "pop from empty queue")
  `MRW_ASSERT(a_push_not_full, clk_i, rst_ni, push_i |-> cnt_q != 2'd2, "push into full queue")

endmodule

// ----- src/mrw_back.sv -----
`include "multicast_receive_window_defines.svh"

module mrw_back import mrw_pkg::*; #(
  parameter int unsigned WINDOW_SLOTS = 32,
  parameter int unsigned GAP_LIST_MAX = 8,
  localparam int unsigned SLOT_W = $clog2(WINDOW_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  item_t             head_i,
  input  logic [SLOT_W-1:0] head_slot_i,
  output logic              pop_o,
  mrw_out_if.source         out_o
);

  localparam int unsigned      CNT_W     = $clog2(GAP_LIST_MAX + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);
  localparam logic [CNT_W-1:0]  LAST_GAP  = CNT_W'(GAP_LIST_MAX - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_STORE = 5'b00010,
    ST_PRIME = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_CLOSE = 5'b10000
  } bk_state_e;

  bk_state_e          state_q, state_d;
  logic signed [31:0] mark_q, mark_d;
  logic [SLOT_W-1:0]  mark_slot_q, mark_slot_d;
  logic [30:0]        next_rel_q, next_rel_d;
  logic [SLOT_W-1:0]  next_rel_slot_q, next_rel_slot_d;
  logic [WINDOW_SLOTS-1:0] valid_q, valid_d;
  logic [31:0]        cursor_q, cursor_d;
  logic [SLOT_W-1:0]  cur_slot_q, cur_slot_d;
  logic [SLOT_W-1:0]  steps_q, steps_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               out_valid_q;
  logic [1:0]         kind_q;
  logic [30:0]        oseq_q;
  logic [7:0]         osnd_q;
  logic [30:0]        oval_q;
  logic signed [31:0] omark_q;
  logic               olast_q;

  logic               load;
  logic [1:0]         load_kind;
  logic [30:0]        load_seq;
  logic [7:0]         load_snd;
  logic [30:0]        load_val;
  logic               load_last;

  logic               ram_we, ram_re;
  logic [SLOT_W-1:0]  ram_raddr;
  entry_t             ram_wdata;
  entry_t             rd_entry;

  logic [31:0]        mark_inc;
  logic [SLOT_W-1:0]  next_slot;
  logic               emit_ok, slot_v, hit, emit_entry, clr, last_step;
  logic               walk_step, walk_done;

  function automatic logic [SLOT_W-1:0] inc_slot(logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

  mrw_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (WINDOW_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_slot_i),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  assign ram_wdata = '{seq: head_i.seq, sender: head_i.sender, value: head_i.value};

  // Evaluation of the slot under the cursor.
  assign mark_inc   = $unsigned(mark_q) + 32'd1;
  assign next_slot  = inc_slot(cur_slot_q);
  assign emit_ok    = !out_valid_q || out_o.ready;
  assign slot_v     = valid_q[cur_slot_q];
  assign hit        = slot_v && ({1'b0, rd_entry.seq} == cursor_q);
  assign emit_entry = slot_v && (rd_entry.seq == cursor_q[30:0]);
  assign clr        = slot_v && (rd_entry.seq <= cursor_q[30:0]);
  assign last_step  = (steps_q == LAST_SLOT);

  // Sequencer: one window slot per cycle, stalling whenever a result cannot be placed.
  always_comb begin
    state_d         = state_q;
    mark_d          = mark_q;
    mark_slot_d     = mark_slot_q;
    next_rel_d      = next_rel_q;
    next_rel_slot_d = next_rel_slot_q;
    valid_d         = valid_q;
    cursor_d        = cursor_q;
    cur_slot_d      = cur_slot_q;
    steps_d         = steps_q;
    cnt_d           = cnt_q;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = cur_slot_q;
    pop_o           = 1'b0;
    load            = 1'b0;
    load_kind       = KIND_CLOSE;
    load_seq        = '0;
    load_snd        = '0;
    load_val        = '0;
    load_last       = 1'b0;
    walk_step       = 1'b0;
    walk_done       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          unique case (head_i.job)
            JOB_DATA: begin
              if (!mark_q[31] && head_i.seq <= mark_q[30:0]) begin
                state_d = ST_CLOSE;
              end else begin
                state_d = ST_STORE;
              end
            end
            JOB_RELEASE: begin
              if (head_i.seq < next_rel_q) begin
                state_d = ST_CLOSE;
              end else begin
                cursor_d   = {1'b0, next_rel_q};
                cur_slot_d = next_rel_slot_q;
                steps_d    = '0;
                state_d    = ST_PRIME;
              end
            end
            JOB_GAP: begin
              if (mark_inc > {1'b0, head_i.seq}) begin
                state_d = ST_CLOSE;
              end else begin
                cursor_d   = mark_inc;
                cur_slot_d = mark_slot_q;
                steps_d    = '0;
                cnt_d      = '0;
                state_d    = ST_PRIME;
              end
            end
            JOB_CLOSE: state_d = ST_CLOSE;
          endcase
        end
      end

      // Store into an empty slot; an in-order arrival then walks the mark forward.
      ST_STORE: begin
        if (!valid_q[head_slot_i]) begin
          ram_we               = 1'b1;
          valid_d[head_slot_i] = 1'b1;
        end
        if ({1'b0, head_i.seq} == mark_inc) begin
          cursor_d   = mark_inc;
          cur_slot_d = mark_slot_q;
          steps_d    = '0;
          state_d    = ST_PRIME;
        end else begin
          state_d = ST_CLOSE;
        end
      end

      ST_PRIME: begin
        ram_re  = 1'b1;
        state_d = ST_WALK;
      end

      ST_WALK: begin
        unique case (head_i.job)
          JOB_DATA: begin
            walk_step = 1'b1;
            walk_done = !hit || last_step;
            if (hit) begin
              mark_d      = $signed(cursor_q);
              mark_slot_d = next_slot;
            end
          end
          JOB_RELEASE: begin
            walk_step = !emit_entry || emit_ok;
            walk_done = (cursor_q[30:0] == head_i.seq) || last_step;
            if (walk_step) begin
              if (emit_entry) begin
                load      = 1'b1;
                load_kind = KIND_ENTRY;
                load_seq  = cursor_q[30:0];
                load_snd  = rd_entry.sender;
                load_val  = rd_entry.value;
              end
              if (clr) begin
                valid_d[cur_slot_q] = 1'b0;
              end
              if (walk_done) begin
                // The next undelivered sequence saturates at the top sequence.
                if (&head_i.seq) begin
                  next_rel_d      = head_i.seq;
                  next_rel_slot_d = head_slot_i;
                end else begin
                  next_rel_d      = head_i.seq + 31'd1;
                  next_rel_slot_d = inc_slot(head_slot_i);
                end
              end
            end
          end
          JOB_GAP: begin
            walk_step = hit || emit_ok;
            walk_done = (cursor_q == {1'b0, head_i.seq}) || (!hit && cnt_q == LAST_GAP);
            if (walk_step && !hit) begin
              load      = 1'b1;
              load_kind = KIND_MISSING;
              load_seq  = cursor_q[30:0];
              cnt_d     = cnt_q + CNT_W'(1);
            end
          end
          JOB_CLOSE: begin
            walk_step = 1'b1;
            walk_done = 1'b1;
          end
        endcase
        if (walk_step) begin
          if (walk_done) begin
            state_d = ST_CLOSE;
          end else begin
            cursor_d   = cursor_q + 32'd1;
            cur_slot_d = next_slot;
            steps_d    = steps_q + SLOT_W'(1);
            ram_re     = 1'b1;
            ram_raddr  = next_slot;
          end
        end
      end

      ST_CLOSE: begin
        if (emit_ok) begin
          load      = 1'b1;
          load_kind = KIND_CLOSE;
          load_last = 1'b1;
          pop_o     = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      mark_q          <= -32'sd1;
      mark_slot_q     <= '0;
      next_rel_q      <= '0;
      next_rel_slot_q <= '0;
      valid_q         <= '0;
      cursor_q        <= '0;
      cur_slot_q      <= '0;
      steps_q         <= '0;
      cnt_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      mark_q          <= mark_d;
      mark_slot_q     <= mark_slot_d;
      next_rel_q      <= next_rel_d;
      next_rel_slot_q <= next_rel_slot_d;
      valid_q         <= valid_d;
      cursor_q        <= cursor_d;
      cur_slot_q      <= cur_slot_d;
      steps_q         <= steps_d;
      cnt_q           <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload; the mark is captured as it stands when the word is built.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= load_kind;
      oseq_q  <= load_seq;
      osnd_q  <= load_snd;
      oval_q  <= load_val;
      omark_q <= mark_q;
      olast_q <= load_last;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.kind              = kind_q;
  assign out_o.out_sequence      = oseq_q;
  assign out_o.out_sender        = osnd_q;
  assign out_o.out_value         = oval_q;
  assign out_o.all_received_mark = omark_q;
  assign out_o.last              = olast_q;

  // The mark only ever moves up by one sequence per cycle.
  `MRW_ASSERT_NEXT(a_mark_step, clk_i, rst_ni, 1'b1,
    (mark_q == $past(mark_q)) || (mark_q == $past(mark_q) + 32'sd1),
    "received mark moved by more than one")
  // A closing word is built only when the queued word is retired.
  `MRW_ASSERT(a_close_retires, clk_i, rst_ni, (load && load_last) |-> (state_q == ST_CLOSE && pop_o),
    "closing word without retiring the operation")
  // The release point changes only at the end of a release walk.
  `MRW_ASSERT(a_release_point, clk_i, rst_ni,
    (next_rel_q != $past(next_rel_q)) |-> ($past(state_q) == ST_WALK && $past(head_i.job) == JOB_RELEASE),
    "release point changed outside a release")

endmodule

// ----- src/multicast_receive_window.sv -----
// Channel   Direction  Handshake        Word
// in_i      input      valid / ready    operation, sequence_req, sender, value
// out_o     output     valid / ready    kind, out_sequence, out_sender, out_value,
//                                       all_received_mark, last
//
// Front: takes one word at a time and a new one only once the last is queued; a data or release
// sequence is first reduced to its window slot one byte per cycle, then queued.
// Back, one slot per cycle while no result is held up: an in-order arrival walks the mark over
// each slot it moves, at most the whole window; another arrival is only stored, an ignored
// one only closes; a release walks at most WINDOW_SLOTS slots, a gap scan to its end or limit.
// Reset clears flags, mark and release point at once; a full output halts release and gap walks.
module multicast_receive_window import mrw_pkg::*; #(
  parameter int unsigned WINDOW_SLOTS = 32,
  parameter int unsigned GAP_LIST_MAX = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mrw_in_if.sink    in_i,
  mrw_out_if.source out_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int unsigned QW     = $bits(item_t) + SLOT_W;

  logic              push, full, pop, head_valid;
  item_t             front_item, head_item;
  logic [SLOT_W-1:0] front_slot, head_slot;
  logic [QW-1:0]     head_word;

  // Front end: accept and classify.
  mrw_front #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .item_o (front_item),
    .slot_o (front_slot),
    .full_i (full)
  );

  // Short queue so either side can stall on its own.
  mrw_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({front_item, front_slot}),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_word),
    .valid_o (head_valid)
  );

  assign head_item = head_word[QW-1:SLOT_W];
  assign head_slot = head_word[SLOT_W-1:0];

  // Back end: window store and slot walks.
  mrw_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .GAP_LIST_MAX (GAP_LIST_MAX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .head_slot_i  (head_slot),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import mrw_pkg::*;

  localparam int         WINDOW        = 32;
  localparam int         GAP_MAX       = 8;
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam longint     SEQ_TOP       = 64'sd2147483647;
  localparam longint     SEQ_BOTTOM    = -64'sd2147483648;
  localparam int         RANDOM_WORDS  = 141;
  localparam int         CALM_WORDS    = 30;
  localparam int         SETTLE_CYCLES = 48;

  // One result word as it leaves the block.
  typedef struct {
    logic [1:0]         kind;
    logic [30:0]        seq;
    logic [7:0]         sender;
    logic [30:0]        value;
    logic signed [31:0] mark;
    logic               last;
  } result_t;

  // Window predictor together with the queue of results it still awaits.
  class window_scoreboard;
    bit          held[WINDOW];
    logic [30:0] held_seq[WINDOW];
    logic [7:0]  held_sender[WINDOW];
    logic [30:0] held_value[WINDOW];
    longint      mark;
    longint      next_rel;
    result_t     awaited[$];
    int          errors;
    int          words;
    int          checked;
    int          delivered;
    int          missing;

    function new();
      foreach (held[i]) held[i] = 1'b0;
      mark      = -1;
      next_rel  = 0;
      errors    = 0;
      words     = 0;
      checked   = 0;
      delivered = 0;
      missing   = 0;
    endfunction

    function int slot_of(longint s);
      return int'(s % WINDOW);
    endfunction

    // A sequence is present only when its slot holds exactly that sequence.
    function bit holds(longint s);
      int k;
      k = slot_of(s);
      return held[k] && (longint'(held_seq[k]) == s);
    endfunction

    function void push(logic [1:0] kind, longint s, logic [7:0] sender,
                       logic [30:0] value, logic last);
      result_t r;
      r.kind   = kind;
      r.seq    = s[30:0];
      r.sender = sender;
      r.value  = value;
      r.mark   = mark[31:0];
      r.last   = last;
      awaited.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // Works out every result that one accepted request word causes.
    function void note_word(logic [1:0] op, logic signed [31:0] seq_req,
                            logic [7:0] sender, logic [30:0] value);
      longint s;
      longint i;
      int     k;
      int     n;
      int     steps;
      s = longint'(seq_req);
      words++;
      case (op)
        OP_DATA: begin
          if (s >= 0 && s > mark) begin
            k = slot_of(s);
            // An occupied slot drops the newcomer.
            if (!held[k]) begin
              held[k]        = 1'b1;
              held_seq[k]    = s[30:0];
              held_sender[k] = sender;
              held_value[k]  = value;
            end
            // Only the next in-order word moves the mark on.
            if (mark + 1 == s) begin
              for (steps = 0; steps < WINDOW && holds(mark + 1); steps++) mark++;
            end
          end
        end
        OP_RELEASE: begin
          if (s >= 0 && s >= next_rel) begin
            for (i = next_rel; i <= s && i < next_rel + WINDOW; i++) begin
              k = slot_of(i);
              if (held[k]) begin
                if (longint'(held_seq[k]) == i) begin
                  push(KIND_ENTRY, i, held_sender[k], held_value[k], 1'b0);
                  delivered++;
                end
                // Stale entries go too; newer ones are left in place.
                if (longint'(held_seq[k]) <= i) held[k] = 1'b0;
              end
            end
            next_rel = (s + 1 > SEQ_TOP) ? SEQ_TOP : s + 1;
          end
        end
        OP_GAP: begin
          if (s >= 0) begin
            n = 0;
            for (i = mark + 1; i <= s && n < GAP_MAX; i++) begin
              if (!holds(i)) begin
                push(KIND_MISSING, i, 8'd0, 31'd0, 1'b0);
                n++;
                missing++;
              end
            end
          end
        end
        default: ;
      endcase
      push(KIND_CLOSE, 0, 8'd0, 31'd0, 1'b1);
    endfunction

    // Compares one accepted result word with the oldest one awaited.
    task check_result(result_t got);
      result_t want;
      checked++;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected word kind %0d seq %0d mark %0d last %0d",
                         got.kind, got.seq, got.mark, got.last));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.seq !== want.seq || got.sender !== want.sender ||
          got.value !== want.value || got.mark !== want.mark || got.last !== want.last) begin
        report($sformatf({"word %0d: got kind %0d seq %0d snd %0d val %0d mark %0d last %0d,",
                          " want kind %0d seq %0d snd %0d val %0d mark %0d last %0d"},
                         checked, got.kind, got.seq, got.sender, got.value, got.mark,
                         got.last, want.kind, want.seq, want.sender, want.value,
                         want.mark, want.last));
      end
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  bit               idle_on = 1'b1;
  int               stall_left = 0;
  window_scoreboard sb = new();

  mrw_in_if  in_if();
  mrw_out_if out_if();

  multicast_receive_window #(
    .WINDOW_SLOTS(WINDOW),
    .GAP_LIST_MAX(GAP_MAX)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result side stalls in random bursts, only while idling is enabled.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left   <= $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Every result word taken by the handshake is checked at once.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.kind   = out_if.kind;
      got.seq    = out_if.out_sequence;
      got.sender = out_if.out_sender;
      got.value  = out_if.out_value;
      got.mark   = out_if.all_received_mark;
      got.last   = out_if.last;
      sb.check_result(got);
    end
  end

  // Offers one request word, possibly after an idle burst, and waits for it to be taken.
  task automatic send_word(logic [1:0] op, longint s, logic [7:0] sender,
                           logic [30:0] value);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= op;
    in_if.sequence_req <= s[31:0];
    in_if.sender       <= sender;
    in_if.value        <= value;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_word(op, s[31:0], sender, value);
  endtask

  // Mostly well-formed traffic around the mark and the release point, with some noise.
  task automatic random_word();
    int         pick;
    int         shade;
    longint     s;
    logic [1:0] op;
    pick  = $urandom_range(0, 99);
    shade = $urandom_range(0, 99);
    if (pick < 50) begin
      op = OP_DATA;
      if (shade < 25) s = sb.mark + 1;
      else if (shade < 55) s = sb.mark + 1 + $urandom_range(1, 12);
      else if (shade < 85) s = sb.next_rel + $urandom_range(0, 12);
      else if (shade < 95) s = sb.mark - $urandom_range(0, 3);
      else s = sb.mark + $urandom_range(13, 40);
    end else if (pick < 72) begin
      op = OP_RELEASE;
      if (shade < 10) s = sb.next_rel - $urandom_range(1, 3);
      else if (shade < 90) s = sb.next_rel + $urandom_range(0, 12);
      else s = sb.next_rel + $urandom_range(32, 60);
    end else if (pick < 92) begin
      op = OP_GAP;
      s  = sb.mark - 1 + $urandom_range(0, 21);
    end else if (pick < 96) begin
      op = OP_UNUSED;
      s  = $urandom_range(0, 1000);
    end else begin
      op = 2'($urandom_range(0, 3));
      s  = -64'sd1 - longint'($urandom_range(0, 32'h7FFF_FFFF));
    end
    send_word(op, s, 8'($urandom), 31'($urandom));
  endtask

  initial begin
    in_if.valid        = 1'b0;
    in_if.operation    = OP_DATA;
    in_if.sequence_req = '0;
    in_if.sender       = '0;
    in_if.value        = '0;
    out_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed opening: empty window, collisions, in-order advance and release corners.
    send_word(OP_GAP, -1, 8'd0, 31'd0);
    send_word(OP_UNUSED, 7, 8'd0, 31'd0);
    send_word(OP_GAP, 5, 8'd0, 31'd0);
    send_word(OP_GAP, 20, 8'd0, 31'd0);
    send_word(OP_DATA, -1, 8'd1, 31'd1);
    send_word(OP_DATA, 0, 8'd0, 31'd0);
    send_word(OP_DATA, 2, 8'hFF, 31'h7FFF_FFFF);
    send_word(OP_DATA, 2, 8'd9, 31'd123);
    send_word(OP_DATA, 34, 8'd10, 31'd5);
    send_word(OP_DATA, 0, 8'd3, 31'd3);
    send_word(OP_DATA, 1, 8'd4, 31'd4);
    send_word(OP_GAP, 10, 8'd0, 31'd0);
    send_word(OP_RELEASE, 1, 8'd0, 31'd0);
    send_word(OP_RELEASE, 0, 8'd0, 31'd0);
    send_word(OP_DATA, 40, 8'd6, 31'd6);
    send_word(OP_RELEASE, 10, 8'd0, 31'd0);
    send_word(OP_DATA, 5, 8'd7, 31'd7);
    send_word(OP_RELEASE, 40, 8'd0, 31'd0);
    send_word(OP_DATA, 3, 8'd8, 31'd8);
    send_word(OP_DATA, 4, 8'd11, 31'd11);
    send_word(OP_RELEASE, 120, 8'd0, 31'd0);
    send_word(OP_GAP, 15, 8'd0, 31'd0);

    // Random traffic; the last stretch runs without any idling.
    for (int w = 0; w < RANDOM_WORDS; w++) begin
      if (w == RANDOM_WORDS - CALM_WORDS) idle_on = 1'b0;
      random_word();
    end

    // Top of the sequence space, which pins the release point for good.
    send_word(OP_RELEASE, SEQ_TOP, 8'd0, 31'd0);
    send_word(OP_DATA, SEQ_TOP, 8'hFF, 31'h7FFF_FFFF);
    send_word(OP_GAP, SEQ_TOP, 8'd0, 31'd0);
    send_word(OP_RELEASE, SEQ_TOP, 8'd0, 31'd0);
    send_word(OP_DATA, SEQ_TOP - 1, 8'd0, 31'd0);
    send_word(OP_RELEASE, SEQ_TOP, 8'd0, 31'd0);
    send_word(OP_GAP, SEQ_BOTTOM, 8'd0, 31'd0);
    in_if.valid <= 1'b0;

    // Drain the results, then give the back end time to show any stray word.
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d request words and %0d result words: %0d delivered entries, %0d gaps.",
             sb.words, sb.checked, sb.delivered, sb.missing);
    $display("Final all-received mark %0d, release point %0d, %0d mismatches.",
             sb.mark, sb.next_rel, sb.errors);
    if (sb.errors == 0) begin
      $display("[multicast_receive_window] OK");
    end else begin
      $display("[multicast_receive_window] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3000000;
    $display("[multicast_receive_window] ERROR");
    $finish;
  end

endmodule
